[hdl/apl_pkg.sv]
`timescale 1ns / 1ps

package apl_pkg;

  // Item selector carried in tuser
  localparam logic FUNC_EVAL = 1'b0;
  localparam logic FUNC_ACK  = 1'b1;

  // Event codes, shared by the acknowledge field and the result kind
  localparam logic [2:0] EV_NORMAL      = 3'd0;
  localparam logic [2:0] EV_FALL        = 3'd1;
  localparam logic [2:0] EV_FALL_NO_GPS = 3'd2;
  localparam logic [2:0] EV_HELP        = 3'd3;
  localparam logic [2:0] EV_FALL_HELP   = 3'd4;
  localparam logic [2:0] EV_LOW_BATT    = 3'd5;

  // Alert severities
  localparam logic [2:0] LVL_NORMAL   = 3'd0;
  localparam logic [2:0] LVL_LOW_BATT = 3'd2;
  localparam logic [2:0] LVL_HELP     = 3'd3;
  localparam logic [2:0] LVL_FALL     = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_FALL_WINDOW = 2'd0;
  localparam logic [1:0] REG_HELP_WINDOW = 2'd1;
  localparam logic [1:0] REG_BATT_THRESH = 2'd2;

  localparam logic [31:0] FALL_WINDOW_RESET = 32'd180000;
  localparam logic [31:0] HELP_WINDOW_RESET = 32'd60000;
  localparam logic [6:0]  BATT_THRESH_RESET = 7'd20;
  localparam logic [6:0]  BATT_MAX          = 7'd100;

  typedef struct packed {
    logic [31:0] fall_window_ms;
    logic [31:0] help_window_ms;
    logic [6:0]  low_battery_threshold;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic        fall_flag;
    logic        audio_valid;
    logic        audio_help;
    logic        gps_valid;
    logic [6:0]  battery_level;
    logic [2:0]  sent_event;
  } item_t;

  typedef struct packed {
    logic [2:0] alert_level;
    logic [2:0] event_kind;
    logic       transmit_now;
  } result_t;

endpackage

[hdl/alert_priority_latch.sv]
`timescale 1ns / 1ps

// Prioritized alert latch for a wearable distress sensor. Every input beat
// (s_tuser = 0 evaluate, 1 acknowledge) yields exactly one result beat on the
// m_ side. An evaluate latches a fall and a rising edge of the help detection
// with their timestamps, raises a pending low-battery alert when the battery
// drops below the threshold, expires latches whose modular 32-bit age exceeds
// their window, and reports one alert in the order fall-then-help, fall, help,
// low battery, normal. An acknowledge marks an event as sent and always returns
// a normal result. The block takes one beat per clock: a beat is held in the
// input register, and the evaluation and latch update happen in a single pass
// between that register and the result register that drives m_, so the state
// seen by a beat already includes every earlier beat. Downstream backpressure
// stalls the input register while the result register holds. Write the
// configuration registers only while no beat is in flight.
module alert_priority_latch
  import apl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], fall_flag[32], audio_valid[33], audio_help[34],
  // gps_valid[35], battery_level[42:36], sent_event[45:43], zero[47:46]
  input  logic [47:0] s_tdata,
  // func[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // alert_level[2:0], event_kind[5:3], transmit_now[6], zero[7]
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t eval_res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  apl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the staged beat into the result register when that register is free
  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the payload of an accepted beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func          <= s_tuser;
      in_item.now_ms        <= s_tdata[31:0];
      in_item.fall_flag     <= s_tdata[32];
      in_item.audio_valid   <= s_tdata[33];
      in_item.audio_help    <= s_tdata[34];
      in_item.gps_valid     <= s_tdata[35];
      in_item.battery_level <= s_tdata[42:36];
      in_item.sent_event    <= s_tdata[45:43];
    end
  end

  apl_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (eval_res)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eval_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.transmit_now, out_res.event_kind, out_res.alert_level};

  // A transmitted alert always names an event, and a silent one never does
  a_tx_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.transmit_now == (out_res.event_kind != EV_NORMAL)))
    else $error("transmit flag disagrees with event kind");

  // Fall-class events carry the fall severity
  a_fall_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.event_kind == EV_FALL || out_res.event_kind == EV_FALL_NO_GPS ||
                   out_res.event_kind == EV_FALL_HELP))
    |-> (out_res.alert_level == LVL_FALL))
    else $error("fall event without fall severity");

  // An acknowledge produces a normal, silent result
  a_ack_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.func == FUNC_ACK) |=> (out_res.transmit_now == 1'b0 &&
                                               out_res.alert_level == LVL_NORMAL))
    else $error("acknowledge produced an alert");

  // Input stalls only when both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled with room in the pipeline");

endmodule

[hdl/apl_cfg.sv]
`timescale 1ns / 1ps

module apl_cfg
  import apl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fall_window_ms        <= FALL_WINDOW_RESET;
      cfg.help_window_ms        <= HELP_WINDOW_RESET;
      cfg.low_battery_threshold <= BATT_THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FALL_WINDOW: cfg.fall_window_ms        <= cfg_data;
        REG_HELP_WINDOW: cfg.help_window_ms        <= cfg_data;
        REG_BATT_THRESH: cfg.low_battery_threshold <= cfg_data[6:0];
        default: ;  // unused index, drop the write
      endcase
    end
  end

endmodule

[hdl/apl_eval.sv]
`timescale 1ns / 1ps

module apl_eval
  import apl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic        fall_latched, help_latched, low_battery_pending;
  logic        fall_reported, help_reported, combined_reported;
  logic        help_seen_before, battery_low_before;
  logic [31:0] fall_time, help_time;

  logic        fall_latched_next, help_latched_next, low_battery_pending_next;
  logic        fall_reported_next, help_reported_next, combined_reported_next;
  logic        help_seen_before_next, battery_low_before_next;
  logic [31:0] fall_time_next, help_time_next;

  logic        help_now, help_edge, low_now;
  logic [6:0]  batt_sat;
  logic [31:0] fall_age, help_age;
  logic        fall_in, help_in, fall_exp, help_exp;
  logic        fall_lat_v, help_lat_v, fall_rep_v, help_rep_v, comb_v;

  assign help_now  = item.audio_valid & item.audio_help;
  assign help_edge = help_now & ~help_seen_before;
  assign batt_sat  = (item.battery_level > BATT_MAX) ? BATT_MAX : item.battery_level;
  assign low_now   = batt_sat < cfg.low_battery_threshold;

  // Ages are taken against the stamp as updated by this item
  assign fall_age = item.now_ms - (item.fall_flag ? item.now_ms : fall_time);
  assign help_age = item.now_ms - (help_edge ? item.now_ms : help_time);
  assign fall_in  = fall_age <= cfg.fall_window_ms;
  assign help_in  = help_age <= cfg.help_window_ms;

  assign fall_lat_v = fall_latched | item.fall_flag;
  assign help_lat_v = help_latched | help_edge;
  assign fall_rep_v = fall_reported & ~item.fall_flag;
  assign help_rep_v = help_reported & ~help_edge;
  assign comb_v     = combined_reported & ~item.fall_flag & ~help_edge;
  assign fall_exp   = fall_lat_v & ~fall_in;
  assign help_exp   = help_lat_v & ~help_in;

  always_comb begin
    fall_latched_next        = fall_latched;
    help_latched_next        = help_latched;
    low_battery_pending_next = low_battery_pending;
    fall_reported_next       = fall_reported;
    help_reported_next       = help_reported;
    combined_reported_next   = combined_reported;
    help_seen_before_next    = help_seen_before;
    battery_low_before_next  = battery_low_before;
    fall_time_next           = fall_time;
    help_time_next           = help_time;
    res = '{alert_level: LVL_NORMAL, event_kind: EV_NORMAL, transmit_now: 1'b0};

    if (item.func == FUNC_ACK) begin
      unique case (item.sent_event) inside
        EV_FALL, EV_FALL_NO_GPS: fall_reported_next = 1'b1;
        EV_HELP:                 help_reported_next = 1'b1;
        EV_FALL_HELP: begin
          fall_reported_next     = 1'b1;
          help_reported_next     = 1'b1;
          combined_reported_next = 1'b1;
        end
        EV_LOW_BATT:             low_battery_pending_next = 1'b0;
        default: ;
      endcase
    end else begin
      fall_time_next           = item.fall_flag ? item.now_ms : fall_time;
      help_time_next           = help_edge ? item.now_ms : help_time;
      help_seen_before_next    = help_now;
      battery_low_before_next  = low_now;
      low_battery_pending_next = low_battery_pending | (low_now & ~battery_low_before);
      fall_latched_next        = fall_lat_v & fall_in;
      help_latched_next        = help_lat_v & help_in;
      fall_reported_next       = fall_rep_v & ~fall_exp;
      help_reported_next       = help_rep_v & ~help_exp;
      combined_reported_next   = comb_v & ~fall_exp & ~help_exp;

      if (fall_latched_next && help_latched_next && help_time_next >= fall_time_next &&
          fall_reported_next && !combined_reported_next) begin
        res = '{alert_level: LVL_FALL, event_kind: EV_FALL_HELP, transmit_now: 1'b1};
      end else if (fall_latched_next && !fall_reported_next) begin
        res = '{alert_level: LVL_FALL,
                event_kind: (item.gps_valid ? EV_FALL : EV_FALL_NO_GPS),
                transmit_now: 1'b1};
      end else if (help_latched_next && !help_reported_next) begin
        res = '{alert_level: LVL_HELP, event_kind: EV_HELP, transmit_now: 1'b1};
      end else if (low_battery_pending_next) begin
        res = '{alert_level: LVL_LOW_BATT, event_kind: EV_LOW_BATT, transmit_now: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_latched        <= 1'b0;
      help_latched        <= 1'b0;
      low_battery_pending <= 1'b0;
      fall_reported       <= 1'b0;
      help_reported       <= 1'b0;
      combined_reported   <= 1'b0;
      help_seen_before    <= 1'b0;
      battery_low_before  <= 1'b0;
      fall_time           <= '0;
      help_time           <= '0;
    end else if (advance) begin
      fall_latched        <= fall_latched_next;
      help_latched        <= help_latched_next;
      low_battery_pending <= low_battery_pending_next;
      fall_reported       <= fall_reported_next;
      help_reported       <= help_reported_next;
      combined_reported   <= combined_reported_next;
      help_seen_before    <= help_seen_before_next;
      battery_low_before  <= battery_low_before_next;
      fall_time           <= fall_time_next;
      help_time           <= help_time_next;
    end
  end

endmodule
